FILE: design/fsdl_pkg.sv
// Shared types and constants for the footswitch debounce and long-press unit.
// No dependencies; used by the lane module and the top level.
`timescale 1ns / 1ps
`default_nettype none

package fsdl_pkg;

   localparam int FIELD_SWITCHES = 4;
   localparam int TIME_WIDTH     = 32;
   localparam int WINDOW_WIDTH   = 8;
   localparam int HOLD_WIDTH     = 16;
   localparam int INDEX_WIDTH    = 2;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 4;

   localparam logic [1:0] REG_DEBOUNCE_TIME     = 2'd0;
   localparam logic [1:0] REG_RECENT_WINDOW     = 2'd1;
   localparam logic [1:0] REG_DEFAULT_HOLD_TIME = 2'd2;

   localparam logic [WINDOW_WIDTH-1:0] DEBOUNCE_RESET = 8'd20;
   localparam logic [WINDOW_WIDTH-1:0] WINDOW_RESET   = 8'd50;
   localparam logic [HOLD_WIDTH-1:0]   HOLD_RESET     = 16'd1000;

   typedef struct packed {
      logic advance;
      logic clear;
      logic set_fired;
   } lane_ctrl_type;

   typedef struct packed {
      logic pressed;
      logic recent;
      logic long_ready;
   } lane_status_type;

endpackage

`default_nettype wire

FILE: design/fsdl_channels.sv
// Valid/ready channel interfaces for the request and response beats.
// Depends on fsdl_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface fsdl_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [fsdl_pkg::TIME_WIDTH-1:0]       now_ms;
   logic [fsdl_pkg::FIELD_SWITCHES-1:0]   raw_levels;
   logic                                  check_pair;
   logic [fsdl_pkg::INDEX_WIDTH-1:0]      first_switch;
   logic [fsdl_pkg::INDEX_WIDTH-1:0]      second_switch;
   logic                                  use_custom_hold;
   logic [fsdl_pkg::HOLD_WIDTH-1:0]       custom_hold_ms;
   logic                                  clear_recent;

   modport source (
      output valid, now_ms, raw_levels, check_pair, first_switch, second_switch,
             use_custom_hold, custom_hold_ms, clear_recent,
      input  ready
   );
   modport sink (
      input  valid, now_ms, raw_levels, check_pair, first_switch, second_switch,
             use_custom_hold, custom_hold_ms, clear_recent,
      output ready
   );
endinterface

interface fsdl_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [fsdl_pkg::FIELD_SWITCHES-1:0]   pressed_mask;
   logic [fsdl_pkg::FIELD_SWITCHES-1:0]   recent_mask;
   logic                                  long_press;

   modport source (
      output valid, pressed_mask, recent_mask, long_press,
      input  ready
   );
   modport sink (
      input  valid, pressed_mask, recent_mask, long_press,
      output ready
   );
endinterface

`default_nettype wire

FILE: design/fsdl_switch_lane.sv
// One switch: debounce state, press start time and long-press flag.
// Depends on fsdl_pkg for widths and the lane control/status structs.
`timescale 1ns / 1ps
`default_nettype none

module fsdl_switch_lane (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire fsdl_pkg::lane_ctrl_type               ctrl,
   input  wire logic [fsdl_pkg::TIME_WIDTH-1:0]       now_ms,
   input  wire logic                                  level,
   input  wire logic [fsdl_pkg::WINDOW_WIDTH-1:0]     debounce_time,
   input  wire logic [fsdl_pkg::WINDOW_WIDTH-1:0]     recent_window,
   input  wire logic [fsdl_pkg::HOLD_WIDTH-1:0]       hold_time,
   output fsdl_pkg::lane_status_type                  status
);

   logic                              stable_ff, stable_in;
   logic                              prev_ff;
   logic                              fired_ff, fired_in;
   logic [fsdl_pkg::TIME_WIDTH-1:0]   change_ff, change_in;
   logic [fsdl_pkg::TIME_WIDTH-1:0]   start_ff, start_in;
   logic [fsdl_pkg::TIME_WIDTH-1:0]   since_change;
   logic [fsdl_pkg::TIME_WIDTH-1:0]   since_press;
   logic                              changed;
   logic                              accept;
   logic                              new_press;
   logic                              fired_mid;

   always_comb begin
      changed      = level != prev_ff;
      change_in    = changed ? now_ms : change_ff;
      since_change = changed ? '0 : now_ms - change_ff;
      accept       = (since_change
                      > {{(fsdl_pkg::TIME_WIDTH-fsdl_pkg::WINDOW_WIDTH){1'b0}},
                         debounce_time})
                     && (level != stable_ff);
      new_press    = accept && !level;
      stable_in    = accept ? level : stable_ff;
      since_press  = new_press ? '0 : now_ms - start_ff;
      fired_mid    = new_press ? 1'b0 : fired_ff;

      status.pressed    = !stable_in;
      status.recent     = !stable_in
                          && (since_press
                              < {{(fsdl_pkg::TIME_WIDTH-fsdl_pkg::WINDOW_WIDTH){1'b0}},
                                 recent_window});
      status.long_ready = !stable_in && !fired_mid
                          && (since_press
                              > {{(fsdl_pkg::TIME_WIDTH-fsdl_pkg::HOLD_WIDTH){1'b0}},
                                 hold_time});

      if (ctrl.clear) begin
         start_in = '0;
      end else if (new_press) begin
         start_in = now_ms;
      end else begin
         start_in = start_ff;
      end
      fired_in = fired_mid || ctrl.set_fired;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff <= 1'b1;
         prev_ff   <= 1'b1;
         fired_ff  <= 1'b0;
         change_ff <= '0;
         start_ff  <= '0;
      end else if (ctrl.advance) begin
         stable_ff <= stable_in;
         prev_ff   <= level;
         fired_ff  <= fired_in;
         change_ff <= change_in;
         start_ff  <= start_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/footswitch_debounce_longpress_unit.sv
// Top level: input register, per-switch lanes, pair test and result register.
// Depends on fsdl_pkg, fsdl_req_if, fsdl_rsp_if and fsdl_switch_lane.
//
//   channel  direction  handshake            contents
//   req      in         valid/ready          time stamp, raw levels, pair test, clear
//   rsp      out        valid/ready          pressed mask, recent mask, long press
//   csr      in         APB psel/penable     debounce, recent window, default hold
//
// One beat per cycle sustained while rsp is not stalled; an accepted beat passes from the
// input register through the lane logic into the result register, which drives rsp.
// Reset is synchronous: switches read released, times and flags zero.
// A stalled rsp holds its result; req keeps accepting while the input
// register can move on into the result register in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module footswitch_debounce_longpress_unit #(
   parameter int SWITCH_COUNT = 4
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   fsdl_req_if.sink                                    req,
   fsdl_rsp_if.source                                  rsp,
   input  wire logic                                   psel,
   input  wire logic                                   penable,
   input  wire logic                                   pwrite,
   input  wire logic [fsdl_pkg::CSR_ADDR_WIDTH-1:0]    paddr,
   input  wire logic [fsdl_pkg::CSR_DATA_WIDTH-1:0]    pwdata,
   output logic      [fsdl_pkg::CSR_DATA_WIDTH-1:0]    prdata,
   output logic                                        pready
);

   logic [fsdl_pkg::WINDOW_WIDTH-1:0]     debounce_ff;
   logic [fsdl_pkg::WINDOW_WIDTH-1:0]     window_ff;
   logic [fsdl_pkg::HOLD_WIDTH-1:0]       hold_default_ff;
   logic                                  csr_write;

   logic                                  in_valid_ff, in_valid_in;
   logic [fsdl_pkg::TIME_WIDTH-1:0]       now_ff;
   logic [fsdl_pkg::FIELD_SWITCHES-1:0]   raw_ff;
   logic                                  check_ff;
   logic [fsdl_pkg::INDEX_WIDTH-1:0]      first_ff;
   logic [fsdl_pkg::INDEX_WIDTH-1:0]      second_ff;
   logic                                  custom_ff;
   logic [fsdl_pkg::HOLD_WIDTH-1:0]       custom_hold_ff;
   logic                                  clear_ff;

   logic                                  out_valid_ff, out_valid_in;
   logic [fsdl_pkg::FIELD_SWITCHES-1:0]   pressed_ff, pressed_in;
   logic [fsdl_pkg::FIELD_SWITCHES-1:0]   recent_ff, recent_in;
   logic                                  long_ff;

   logic                                  req_take;
   logic                                  advance;
   logic                                  pair_ok;
   logic                                  fire;
   logic [fsdl_pkg::HOLD_WIDTH-1:0]       hold_sel;
   logic [SWITCH_COUNT-1:0]               hit;
   logic [SWITCH_COUNT-1:0]               blocked;
   logic [SWITCH_COUNT-1:0]               lane_level;
   fsdl_pkg::lane_ctrl_type               lane_ctrl   [SWITCH_COUNT];
   fsdl_pkg::lane_status_type             lane_status [SWITCH_COUNT];

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      case (paddr[3:2])
         fsdl_pkg::REG_DEBOUNCE_TIME:
            prdata = {{(fsdl_pkg::CSR_DATA_WIDTH-fsdl_pkg::WINDOW_WIDTH){1'b0}}, debounce_ff};
         fsdl_pkg::REG_RECENT_WINDOW:
            prdata = {{(fsdl_pkg::CSR_DATA_WIDTH-fsdl_pkg::WINDOW_WIDTH){1'b0}}, window_ff};
         fsdl_pkg::REG_DEFAULT_HOLD_TIME:
            prdata = {{(fsdl_pkg::CSR_DATA_WIDTH-fsdl_pkg::HOLD_WIDTH){1'b0}},
                      hold_default_ff};
         default:
            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff     <= fsdl_pkg::DEBOUNCE_RESET;
         window_ff       <= fsdl_pkg::WINDOW_RESET;
         hold_default_ff <= fsdl_pkg::HOLD_RESET;
      end else if (csr_write) begin
         case (paddr[3:2])
            fsdl_pkg::REG_DEBOUNCE_TIME:
               debounce_ff <= pwdata[fsdl_pkg::WINDOW_WIDTH-1:0];
            fsdl_pkg::REG_RECENT_WINDOW:
               window_ff <= pwdata[fsdl_pkg::WINDOW_WIDTH-1:0];
            fsdl_pkg::REG_DEFAULT_HOLD_TIME:
               hold_default_ff <= pwdata[fsdl_pkg::HOLD_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // handshake
   assign advance     = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready   = !in_valid_ff || advance;
   assign req_take    = req.valid && req.ready;
   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         now_ff         <= req.now_ms;
         raw_ff         <= req.raw_levels;
         check_ff       <= req.check_pair;
         first_ff       <= req.first_switch;
         second_ff      <= req.second_switch;
         custom_ff      <= req.use_custom_hold;
         custom_hold_ff <= req.custom_hold_ms;
         clear_ff       <= req.clear_recent;
      end
   end

   // pair test
   assign hold_sel = custom_ff ? custom_hold_ff : hold_default_ff;
   assign pair_ok  = check_ff && (32'(first_ff) < SWITCH_COUNT)
                     && (32'(second_ff) < SWITCH_COUNT);
   assign fire     = pair_ok && !(|blocked);

   for (genvar k = 0; k < SWITCH_COUNT; k++) begin : g_lane
      if (k < fsdl_pkg::FIELD_SWITCHES) begin : g_raw
         assign lane_level[k] = raw_ff[k];
      end else begin : g_tied
         assign lane_level[k] = 1'b0;
      end

      assign hit[k]     = (32'(first_ff) == 32'(k)) || (32'(second_ff) == 32'(k));
      assign blocked[k] = hit[k] && !lane_status[k].long_ready;

      assign lane_ctrl[k].advance   = advance;
      assign lane_ctrl[k].clear     = clear_ff;
      assign lane_ctrl[k].set_fired = fire && hit[k];

      fsdl_switch_lane u_lane (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (lane_ctrl[k]),
         .now_ms        (now_ff),
         .level         (lane_level[k]),
         .debounce_time (debounce_ff),
         .recent_window (window_ff),
         .hold_time     (hold_sel),
         .status        (lane_status[k])
      );
   end

   for (genvar j = 0; j < fsdl_pkg::FIELD_SWITCHES; j++) begin : g_mask
      if (j < SWITCH_COUNT) begin : g_live
         assign pressed_in[j] = lane_status[j].pressed;
         assign recent_in[j]  = lane_status[j].recent;
      end else begin : g_absent
         assign pressed_in[j] = 1'b0;
         assign recent_in[j]  = 1'b0;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (advance) begin
         pressed_ff <= pressed_in;
         recent_ff  <= recent_in;
         long_ff    <= fire;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.pressed_mask = pressed_ff;
   assign rsp.recent_mask  = recent_ff;
   assign rsp.long_press   = long_ff;

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking bench for footswitch_debounce_longpress_unit: directed press timing
// cases, then random pedal traffic under several register settings and idle mixes.
// Depends on fsdl_pkg, fsdl_req_if, fsdl_rsp_if and the design top level.
`timescale 1ns / 1ps

module tb;

   typedef struct packed {
      logic [fsdl_pkg::TIME_WIDTH-1:0]     now_ms;
      logic [fsdl_pkg::FIELD_SWITCHES-1:0] raw_levels;
      logic                                check_pair;
      logic [fsdl_pkg::INDEX_WIDTH-1:0]    first_switch;
      logic [fsdl_pkg::INDEX_WIDTH-1:0]    second_switch;
      logic                                use_custom_hold;
      logic [fsdl_pkg::HOLD_WIDTH-1:0]     custom_hold_ms;
      logic                                clear_recent;
   } press_sample_type;

   typedef struct packed {
      logic [fsdl_pkg::FIELD_SWITCHES-1:0] pressed_mask;
      logic [fsdl_pkg::FIELD_SWITCHES-1:0] recent_mask;
      logic                                long_press;
   } switch_report_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                psel, penable, pwrite;
   logic [fsdl_pkg::CSR_ADDR_WIDTH-1:0] paddr;
   logic [fsdl_pkg::CSR_DATA_WIDTH-1:0] pwdata;
   logic [fsdl_pkg::CSR_DATA_WIDTH-1:0] prdata;
   logic                                pready;

   fsdl_req_if req_if ();
   fsdl_rsp_if rsp_if ();

   footswitch_debounce_longpress_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .rsp     (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // tracked switch state and register copies
   logic [fsdl_pkg::WINDOW_WIDTH-1:0]   debounce_ms;
   logic [fsdl_pkg::WINDOW_WIDTH-1:0]   window_ms;
   logic [fsdl_pkg::HOLD_WIDTH-1:0]     hold_ms;
   logic                                debounced [fsdl_pkg::FIELD_SWITCHES];
   logic                                last_raw [fsdl_pkg::FIELD_SWITCHES];
   logic [fsdl_pkg::TIME_WIDTH-1:0]     changed_at [fsdl_pkg::FIELD_SWITCHES];
   logic [fsdl_pkg::TIME_WIDTH-1:0]     pressed_at [fsdl_pkg::FIELD_SWITCHES];
   logic                                long_done [fsdl_pkg::FIELD_SWITCHES];

   switch_report_type                   pending_reports [$];
   int                                  mismatch_count = 0;
   int                                  send_idle_pct = 0;
   int                                  sink_stall_pct = 0;
   logic [fsdl_pkg::TIME_WIDTH-1:0]     wall_ms;
   logic [fsdl_pkg::FIELD_SWITCHES-1:0] intent_levels;

   always #5 clock = ~clock;

   function automatic switch_report_type advance_switches(input press_sample_type s);
      switch_report_type               r;
      logic                            lvl;
      logic [fsdl_pkg::TIME_WIDTH-1:0] elapsed;
      logic [fsdl_pkg::TIME_WIDTH-1:0] limit;
      logic [fsdl_pkg::TIME_WIDTH-1:0] held_a;
      logic [fsdl_pkg::TIME_WIDTH-1:0] held_b;
      int                              a;
      int                              b;
      r = '0;
      for (int k = 0; k < fsdl_pkg::FIELD_SWITCHES; k++) begin
         lvl = s.raw_levels[k];
         if (lvl != last_raw[k]) changed_at[k] = s.now_ms;
         elapsed = s.now_ms - changed_at[k];
         if (elapsed > {{(fsdl_pkg::TIME_WIDTH-fsdl_pkg::WINDOW_WIDTH){1'b0}}, debounce_ms}
             && lvl != debounced[k]) begin
            debounced[k] = lvl;
            if (!lvl) begin
               pressed_at[k] = s.now_ms;
               long_done[k]  = 1'b0;
            end
         end
         last_raw[k] = lvl;
      end
      for (int k = 0; k < fsdl_pkg::FIELD_SWITCHES; k++) begin
         if (!debounced[k]) begin
            r.pressed_mask[k] = 1'b1;
            elapsed = s.now_ms - pressed_at[k];
            if (elapsed < {{(fsdl_pkg::TIME_WIDTH-fsdl_pkg::WINDOW_WIDTH){1'b0}}, window_ms})
               r.recent_mask[k] = 1'b1;
         end
      end
      if (s.check_pair) begin
         a = int'(s.first_switch);
         b = int'(s.second_switch);
         limit = s.use_custom_hold
                 ? {{(fsdl_pkg::TIME_WIDTH-fsdl_pkg::HOLD_WIDTH){1'b0}}, s.custom_hold_ms}
                 : {{(fsdl_pkg::TIME_WIDTH-fsdl_pkg::HOLD_WIDTH){1'b0}}, hold_ms};
         held_a = s.now_ms - pressed_at[a];
         held_b = s.now_ms - pressed_at[b];
         if (!debounced[a] && !debounced[b] && !long_done[a] && !long_done[b]
             && held_a > limit && held_b > limit) begin
            long_done[a] = 1'b1;
            long_done[b] = 1'b1;
            r.long_press = 1'b1;
         end
      end
      if (s.clear_recent)
         for (int k = 0; k < fsdl_pkg::FIELD_SWITCHES; k++) pressed_at[k] = '0;
      return r;
   endfunction

   function automatic press_sample_type make_sample(
      input logic [fsdl_pkg::TIME_WIDTH-1:0] now,
      input logic [fsdl_pkg::FIELD_SWITCHES-1:0] raw,
      input int check, input int a, input int b, input int custom,
      input int hold, input int clear);
      press_sample_type s;
      s.now_ms          = now;
      s.raw_levels      = raw;
      s.check_pair      = check[0];
      s.first_switch    = a[fsdl_pkg::INDEX_WIDTH-1:0];
      s.second_switch   = b[fsdl_pkg::INDEX_WIDTH-1:0];
      s.use_custom_hold = custom[0];
      s.custom_hold_ms  = hold[fsdl_pkg::HOLD_WIDTH-1:0];
      s.clear_recent    = clear[0];
      return s;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
   endtask

   task automatic send_sample(input press_sample_type s);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid           <= 1'b1;
      req_if.now_ms          <= s.now_ms;
      req_if.raw_levels      <= s.raw_levels;
      req_if.check_pair      <= s.check_pair;
      req_if.first_switch    <= s.first_switch;
      req_if.second_switch   <= s.second_switch;
      req_if.use_custom_hold <= s.use_custom_hold;
      req_if.custom_hold_ms  <= s.custom_hold_ms;
      req_if.clear_recent    <= s.clear_recent;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pending_reports.push_back(advance_switches(s));
   endtask

   task automatic drain_pipeline();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
      logic [fsdl_pkg::CSR_ADDR_WIDTH-1:0] addr;
      logic [31:0]                         want;
      addr = {idx, 2'b00};
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         fsdl_pkg::REG_DEBOUNCE_TIME:     debounce_ms = value[fsdl_pkg::WINDOW_WIDTH-1:0];
         fsdl_pkg::REG_RECENT_WINDOW:     window_ms   = value[fsdl_pkg::WINDOW_WIDTH-1:0];
         fsdl_pkg::REG_DEFAULT_HOLD_TIME: hold_ms     = value[fsdl_pkg::HOLD_WIDTH-1:0];
         default: ;
      endcase
      want = value;
      // read back through a fresh setup and access
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== want) report_mismatch("register read back", prdata, want);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_registers(input int deb, input int win, input int hold);
      drain_pipeline();
      write_register(fsdl_pkg::REG_DEBOUNCE_TIME, deb);
      write_register(fsdl_pkg::REG_RECENT_WINDOW, win);
      write_register(fsdl_pkg::REG_DEFAULT_HOLD_TIME, hold);
   endtask

   task automatic run_pedal_traffic(input int count);
      press_sample_type s;
      int               pick;
      for (int i = 0; i < count; i++) begin
         s = '0;
         if ($urandom_range(99) < 12) begin
            s.now_ms          = $urandom();
            s.raw_levels      = 4'($urandom_range(15));
            s.check_pair      = 1'($urandom_range(1));
            s.first_switch    = 2'($urandom_range(3));
            s.second_switch   = 2'($urandom_range(3));
            s.use_custom_hold = 1'($urandom_range(1));
            s.custom_hold_ms  = 16'($urandom_range(65535));
            s.clear_recent    = 1'($urandom_range(1));
            wall_ms       = s.now_ms;
            intent_levels = s.raw_levels;
         end else begin
            if ($urandom_range(99) < 10) wall_ms += $urandom_range(3000);
            else wall_ms += $urandom_range(40);
            pick = $urandom_range(3);
            if ($urandom_range(99) < 7) intent_levels[pick] = ~intent_levels[pick];
            s.raw_levels = intent_levels;
            pick = $urandom_range(3);
            if ($urandom_range(99) < 10) s.raw_levels[pick] = ~s.raw_levels[pick];
            s.now_ms          = wall_ms;
            s.check_pair      = ($urandom_range(99) < 40);
            s.first_switch    = 2'($urandom_range(3));
            s.second_switch   = 2'($urandom_range(3));
            s.use_custom_hold = 1'($urandom_range(1));
            if ($urandom_range(99) < 70) s.custom_hold_ms = 16'($urandom_range(200));
            else s.custom_hold_ms = 16'($urandom_range(65535));
            s.clear_recent    = ($urandom_range(99) < 4);
         end
         send_sample(s);
      end
   endtask

   task automatic test_press_timing();
      send_idle_pct  = 0;
      sink_stall_pct = 0;
      send_sample(make_sample(0, 4'hF, 0, 0, 0, 0, 0, 0));
      send_sample(make_sample(5, 4'hE, 0, 0, 0, 0, 0, 0));
      send_sample(make_sample(25, 4'hE, 0, 0, 0, 0, 0, 0));
      send_sample(make_sample(26, 4'hE, 0, 0, 0, 0, 0, 0));
      send_sample(make_sample(27, 4'hF, 0, 0, 0, 0, 0, 0));
      send_sample(make_sample(28, 4'hE, 0, 0, 0, 0, 0, 0));
      send_sample(make_sample(75, 4'hE, 1, 0, 0, 0, 0, 0));
      send_sample(make_sample(76, 4'hE, 0, 0, 0, 0, 0, 0));
      send_sample(make_sample(1026, 4'hE, 1, 0, 0, 0, 0, 0));
      send_sample(make_sample(1027, 4'hE, 1, 0, 0, 0, 0, 0));
      send_sample(make_sample(1028, 4'hE, 1, 0, 0, 0, 0, 0));
      send_sample(make_sample(1030, 4'h0, 0, 0, 0, 0, 0, 0));
      send_sample(make_sample(1051, 4'h0, 0, 0, 0, 0, 0, 0));
      send_sample(make_sample(1060, 4'h0, 1, 1, 2, 1, 0, 1));
      send_sample(make_sample(1061, 4'h0, 1, 3, 0, 1, 65535, 0));
      send_sample(make_sample(32'hFFFF_FFFF, 4'h0, 1, 3, 3, 1, 65535, 0));
      send_sample(make_sample(0, 4'hF, 0, 0, 0, 0, 0, 0));
      send_sample(make_sample(21, 4'hF, 0, 0, 0, 0, 0, 0));
      send_sample(make_sample(22, 4'h5, 0, 0, 0, 0, 0, 0));
      send_sample(make_sample(43, 4'h5, 0, 0, 0, 0, 0, 0));
      send_sample(make_sample(44, 4'hA, 0, 0, 0, 0, 0, 0));
      send_sample(make_sample(65, 4'hA, 1, 1, 3, 0, 0, 0));
      send_sample(make_sample(100, 4'hA, 1, 0, 2, 1, 34, 1));
   endtask

   task automatic test_default_traffic();
      wall_ms        = 32'd200;
      intent_levels  = 4'hA;
      send_idle_pct  = 0;
      sink_stall_pct = 0;
      run_pedal_traffic(300);
   endtask

   task automatic test_fast_settings();
      set_registers(0, 255, 0);
      send_idle_pct  = 77;
      sink_stall_pct = 0;
      run_pedal_traffic(300);
   endtask

   task automatic test_slow_settings();
      set_registers(255, 0, 65535);
      send_idle_pct  = 0;
      sink_stall_pct = 77;
      run_pedal_traffic(300);
   endtask

   task automatic test_random_settings();
      for (int p = 0; p < 2; p++) begin
         set_registers($urandom_range(40), $urandom_range(255), $urandom_range(1500));
         send_idle_pct  = 30;
         sink_stall_pct = 30;
         run_pedal_traffic(200);
      end
   endtask

   task automatic test_time_wrap();
      set_registers(5, 100, 300);
      wall_ms        = 32'hFFFF_F000;
      send_idle_pct  = 0;
      sink_stall_pct = 0;
      run_pedal_traffic(250);
   endtask

   always @(negedge clock) rsp_if.ready <= ($urandom_range(99) >= sink_stall_pct);

   always @(posedge clock) begin
      switch_report_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_reports.size() == 0) begin
            report_mismatch("beat with nothing pending",
                            32'({rsp_if.pressed_mask, rsp_if.recent_mask,
                                 rsp_if.long_press}), 0);
         end else begin
            want = pending_reports.pop_front();
            if (rsp_if.pressed_mask !== want.pressed_mask)
               report_mismatch("pressed_mask", 32'(rsp_if.pressed_mask),
                               32'(want.pressed_mask));
            if (rsp_if.recent_mask !== want.recent_mask)
               report_mismatch("recent_mask", 32'(rsp_if.recent_mask),
                               32'(want.recent_mask));
            if (rsp_if.long_press !== want.long_press)
               report_mismatch("long_press", 32'(rsp_if.long_press),
                               32'(want.long_press));
         end
      end
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      req_if.valid           = 1'b0;
      req_if.now_ms          = '0;
      req_if.raw_levels      = '1;
      req_if.check_pair      = 1'b0;
      req_if.first_switch    = '0;
      req_if.second_switch   = '0;
      req_if.use_custom_hold = 1'b0;
      req_if.custom_hold_ms  = '0;
      req_if.clear_recent    = 1'b0;
      psel                   = 1'b0;
      penable                = 1'b0;
      pwrite                 = 1'b0;
      paddr                  = '0;
      pwdata                 = '0;
      debounce_ms            = fsdl_pkg::DEBOUNCE_RESET;
      window_ms              = fsdl_pkg::WINDOW_RESET;
      hold_ms                = fsdl_pkg::HOLD_RESET;
      wall_ms                = '0;
      intent_levels          = '1;
      for (int k = 0; k < fsdl_pkg::FIELD_SWITCHES; k++) begin
         debounced[k]  = 1'b1;
         last_raw[k]   = 1'b1;
         changed_at[k] = '0;
         pressed_at[k] = '0;
         long_done[k]  = 1'b0;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_press_timing();
      test_default_traffic();
      test_fast_settings();
      test_slow_settings();
      test_random_settings();
      test_time_wrap();
      drain_pipeline();

      if (mismatch_count == 0 && pending_reports.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: sim.f
design/fsdl_pkg.sv
design/fsdl_channels.sv
design/fsdl_switch_lane.sv
design/footswitch_debounce_longpress_unit.sv
tb/tb.sv
